>>> rtl/core/raid1_mirror_dispatch_macros.svh
// Assertion helpers for the mirror dispatch block.
// Both expect i_clk and i_rst_n in the scope where they are used.
`ifndef RAID1_MIRROR_DISPATCH_MACROS_SVH
`define RAID1_MIRROR_DISPATCH_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define R1MD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define R1MD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/r1md_pkg.sv
// ----------------------------------------------------------------------------
// r1md_pkg
// Shared types and codes of the mirror dispatch block.
// ----------------------------------------------------------------------------
`default_nettype none

package r1md_pkg;

    localparam int OP_W     = 3;
    localparam int LBA_W    = 48;
    localparam int PHYS_W   = 49;
    localparam int OFS_W    = 32;
    localparam int IDX_W    = 3;
    localparam int DISK_W   = 3;
    localparam int VOL_W    = 3;
    localparam int ST_W     = 3;
    localparam int NC_W     = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    // opcodes
    localparam logic [OP_W-1:0] OP_READ  = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 3'd1;
    localparam logic [OP_W-1:0] OP_SET   = 3'd2;
    localparam logic [OP_W-1:0] OP_IOERR = 3'd3;
    localparam logic [OP_W-1:0] OP_LOAD  = 3'd4;

    // disk status
    localparam logic [DISK_W-1:0] DS_ONLINE   = 3'd0;
    localparam logic [DISK_W-1:0] DS_OFFLINE  = 3'd1;
    localparam logic [DISK_W-1:0] DS_SCRUB    = 3'd2;
    localparam logic [DISK_W-1:0] DS_REBUILD  = 3'd3;
    localparam logic [DISK_W-1:0] DS_HOTSPARE = 3'd4;

    // volume status
    localparam logic [VOL_W-1:0] VS_ONLINE   = 3'd0;
    localparam logic [VOL_W-1:0] VS_OFFLINE  = 3'd1;
    localparam logic [VOL_W-1:0] VS_DEGRADED = 3'd2;
    localparam logic [VOL_W-1:0] VS_SCRUB    = 3'd3;
    localparam logic [VOL_W-1:0] VS_REBUILD  = 3'd4;
    localparam logic [VOL_W-1:0] VS_BUILDING = 3'd5;

    // result status
    localparam logic [ST_W-1:0] ST_OK         = 3'd0;
    localparam logic [ST_W-1:0] ST_RD_OFFLINE = 3'd1;
    localparam logic [ST_W-1:0] ST_BAD_DISK   = 3'd2;
    localparam logic [ST_W-1:0] ST_BAD_VOL    = 3'd3;
    localparam logic [ST_W-1:0] ST_NO_TARGET  = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CHUNKS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_META_OFFSET = 1'b1;

    typedef enum logic [2:0] {
        CLS_NOP,
        CLS_READ,
        CLS_WRITE,
        CLS_SET,
        CLS_LOAD
    } t_cls;

    typedef struct packed {
        t_cls                cls;
        logic [PHYS_W-1:0]   phys;
        logic [IDX_W-1:0]    idx;
        logic [DISK_W-1:0]   ns;
    } t_cmd;

    typedef struct packed {
        logic [ST_W-1:0]     status;
        logic [IDX_W-1:0]    target;
        logic [PHYS_W-1:0]   phys;
        logic                is_write;
        logic [VOL_W-1:0]    vol;
        logic                last;
    } t_res;

endpackage

`default_nettype wire

>>> rtl/core/r1md_fifo.sv
// ----------------------------------------------------------------------------
// r1md_fifo
// Small register queue, used between front and back and on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module r1md_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/r1md_front.sv
// ----------------------------------------------------------------------------
// r1md_front
// Classifies an incoming transaction and forms its physical block address.
// ----------------------------------------------------------------------------
`default_nettype none

module r1md_front (
    input  wire logic [r1md_pkg::OP_W-1:0]   i_opcode,
    input  wire logic [r1md_pkg::LBA_W-1:0]  i_lba,
    input  wire logic [r1md_pkg::IDX_W-1:0]  i_disk_index,
    input  wire logic [r1md_pkg::DISK_W-1:0] i_new_disk_state,
    input  wire logic [r1md_pkg::OFS_W-1:0]  i_meta_offset,
    output r1md_pkg::t_cmd                   o_cmd
);

    always_comb begin
        o_cmd.phys = r1md_pkg::PHYS_W'(i_lba) + r1md_pkg::PHYS_W'(i_meta_offset);
        o_cmd.idx  = i_disk_index;
        o_cmd.ns   = i_new_disk_state;
        case (i_opcode)
            r1md_pkg::OP_READ:  o_cmd.cls = r1md_pkg::CLS_READ;
            r1md_pkg::OP_WRITE: o_cmd.cls = r1md_pkg::CLS_WRITE;
            r1md_pkg::OP_SET:   o_cmd.cls = r1md_pkg::CLS_SET;
            r1md_pkg::OP_IOERR: begin
                // an error report is a checked move to offline
                o_cmd.cls = r1md_pkg::CLS_SET;
                o_cmd.ns  = r1md_pkg::DS_OFFLINE;
            end
            r1md_pkg::OP_LOAD:  o_cmd.cls = r1md_pkg::CLS_LOAD;
            default:            o_cmd.cls = r1md_pkg::CLS_NOP;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/r1md_back.sv
// ----------------------------------------------------------------------------
// r1md_back
// Execution engine: holds disk and volume state, walks disks one per cycle while the result queue is not full.
// ----------------------------------------------------------------------------
`default_nettype none

module r1md_back #(
    parameter int MAX_DISKS = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [r1md_pkg::NC_W-1:0]  i_num_chunks,
    input  wire r1md_pkg::t_cmd             i_cmd,
    input  wire logic                       i_cmd_valid,
    output logic                            o_cmd_pop,
    output r1md_pkg::t_res                  o_res,
    output logic                            o_res_push,
    input  wire logic                       i_res_full
);

    localparam int NIDX  = 1 << r1md_pkg::IDX_W;
    localparam int NDISK = (MAX_DISKS < NIDX) ? MAX_DISKS : NIDX;
    localparam int DI_W  = (NDISK > 1) ? $clog2(NDISK) : 1;
    localparam int IW    = r1md_pkg::IDX_W;
    localparam int DW    = r1md_pkg::DISK_W;
    localparam int VW    = r1md_pkg::VOL_W;
    localparam int NW    = r1md_pkg::NC_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WRITE,
        S_ONE
    } t_state;

    typedef logic [NIDX-1:0][DW-1:0] t_view;

    function automatic logic [VW:0] derive_vol(input t_view ds, input logic [NIDX-1:0] u);
        logic          all_on;
        logic          any_on;
        logic          any_sc;
        logic          any_rb;
        logic          any_off;
        logic          any_bad;
        logic          ok;
        logic [VW-1:0] v;
        all_on  = 1'b1;
        any_on  = 1'b0;
        any_sc  = 1'b0;
        any_rb  = 1'b0;
        any_off = 1'b0;
        any_bad = 1'b0;
        for (int i = 0; i < NIDX; i++) begin
            if (u[i]) begin
                all_on  = all_on  & (ds[i] == r1md_pkg::DS_ONLINE);
                any_on  = any_on  | (ds[i] == r1md_pkg::DS_ONLINE);
                any_sc  = any_sc  | (ds[i] == r1md_pkg::DS_SCRUB);
                any_rb  = any_rb  | (ds[i] == r1md_pkg::DS_REBUILD);
                any_off = any_off | (ds[i] == r1md_pkg::DS_OFFLINE);
                any_bad = any_bad | (ds[i] > r1md_pkg::DS_HOTSPARE);
            end
        end
        ok = ~any_bad;
        v  = r1md_pkg::VS_ONLINE;
        if (all_on) begin
            v = r1md_pkg::VS_ONLINE;
        end else if (!any_on) begin
            v = r1md_pkg::VS_OFFLINE;
        end else if (any_sc) begin
            v = r1md_pkg::VS_SCRUB;
        end else if (any_rb) begin
            v = r1md_pkg::VS_REBUILD;
        end else if (any_off) begin
            v = r1md_pkg::VS_DEGRADED;
        end else begin
            ok = 1'b0;
        end
        return {ok, v};
    endfunction

    function automatic logic disk_move_ok(input logic [DW-1:0] from, input logic [DW-1:0] to);
        logic ok;
        case (from)
            r1md_pkg::DS_ONLINE:   ok = (to == r1md_pkg::DS_OFFLINE) ||
                                        (to == r1md_pkg::DS_SCRUB);
            r1md_pkg::DS_OFFLINE:  ok = (to == r1md_pkg::DS_REBUILD);
            r1md_pkg::DS_SCRUB:    ok = (to == r1md_pkg::DS_ONLINE);
            r1md_pkg::DS_REBUILD:  ok = (to == r1md_pkg::DS_ONLINE);
            r1md_pkg::DS_HOTSPARE: ok = (to == r1md_pkg::DS_REBUILD);
            default:               ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic vol_move_ok(input logic [VW-1:0] from, input logic [VW-1:0] to);
        logic ok;
        case (from)
            r1md_pkg::VS_ONLINE:   ok = (to == r1md_pkg::VS_OFFLINE) ||
                                        (to == r1md_pkg::VS_DEGRADED);
            r1md_pkg::VS_SCRUB:    ok = (to == r1md_pkg::VS_ONLINE) ||
                                        (to == r1md_pkg::VS_OFFLINE) ||
                                        (to == r1md_pkg::VS_DEGRADED) ||
                                        (to == r1md_pkg::VS_SCRUB);
            r1md_pkg::VS_BUILDING: ok = (to == r1md_pkg::VS_ONLINE) ||
                                        (to == r1md_pkg::VS_OFFLINE) ||
                                        (to == r1md_pkg::VS_BUILDING);
            r1md_pkg::VS_REBUILD:  ok = (to == r1md_pkg::VS_ONLINE) ||
                                        (to == r1md_pkg::VS_OFFLINE) ||
                                        (to == r1md_pkg::VS_REBUILD);
            r1md_pkg::VS_DEGRADED: ok = (to == r1md_pkg::VS_OFFLINE) ||
                                        (to == r1md_pkg::VS_REBUILD) ||
                                        (to == r1md_pkg::VS_DEGRADED);
            default:               ok = 1'b0;
        endcase
        return ok;
    endfunction

    t_state          r_state, n_state;
    r1md_pkg::t_cmd  r_cmd, n_cmd;
    logic [NW-1:0]   r_try, n_try;
    logic [IW-1:0]   r_wi, n_wi;
    logic [IW-1:0]   r_rp, n_rp;
    logic [VW-1:0]   r_vol, n_vol;
    logic [DW-1:0]   r_ds [NDISK];
    logic            ds_we;

    logic [NW-1:0]   nc;
    logic [NIDX-1:0] used;
    t_view           v_ds;
    t_view           tmp;
    logic [VW:0]     drv;
    logic [IW-1:0]   rd_x;
    logic [NW-1:0]   rd_x1;
    logic [IW-1:0]   rd_nx;
    logic [DW-1:0]   rd_s;
    logic [NIDX-1:0] wq;
    logic            w_bad;
    logic            w_more;
    logic            idx_used;
    logic            idx_stored;
    logic [DW-1:0]   cur;

    // effective disk count: zero acts as one, clipped to the stored disks
    always_comb begin
        if (i_num_chunks == '0) begin
            nc = NW'(1);
        end else if (i_num_chunks > NW'(NDISK)) begin
            nc = NW'(NDISK);
        end else begin
            nc = i_num_chunks;
        end
    end

    for (genvar g = 0; g < NIDX; g++) begin : g_view
        assign used[g] = (NW'(g) < nc);
        if (g < NDISK) begin : g_live
            assign v_ds[g] = r_ds[g];
        end else begin : g_pad
            assign v_ds[g] = r1md_pkg::DS_ONLINE;
        end
    end

    always_comb begin
        tmp = v_ds;
        tmp[r_cmd.idx] = r_cmd.ns;
    end

    assign drv        = derive_vol(tmp, used);
    assign cur        = v_ds[r_cmd.idx];
    assign idx_used   = ({1'b0, r_cmd.idx} < nc);
    assign idx_stored = ({1'b0, r_cmd.idx} < NW'(NDISK));

    // read pointer step
    assign rd_x  = ({1'b0, r_rp} >= nc) ? '0 : r_rp;
    assign rd_x1 = {1'b0, rd_x} + NW'(1);
    assign rd_nx = (rd_x1 >= nc) ? '0 : rd_x1[IW-1:0];
    assign rd_s  = v_ds[rd_x];

    // write targets
    always_comb begin
        w_bad  = 1'b0;
        w_more = 1'b0;
        for (int i = 0; i < NIDX; i++) begin
            wq[i] = used[i] && ((v_ds[i] == r1md_pkg::DS_ONLINE) ||
                                (v_ds[i] == r1md_pkg::DS_SCRUB) ||
                                (v_ds[i] == r1md_pkg::DS_REBUILD));
            w_bad = w_bad | (used[i] && (v_ds[i] > r1md_pkg::DS_HOTSPARE));
        end
        for (int j = 0; j < NIDX; j++) begin
            if ((IW'(j) > r_wi) && wq[j]) begin
                w_more = 1'b1;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_try      = r_try;
        n_wi       = r_wi;
        n_rp       = r_rp;
        n_vol      = r_vol;
        ds_we      = 1'b0;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        o_res.last = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_try     = '0;
                    n_wi      = '0;
                    case (i_cmd.cls)
                        r1md_pkg::CLS_READ:  n_state = S_READ;
                        r1md_pkg::CLS_WRITE: n_state = S_WRITE;
                        default:             n_state = S_ONE;
                    endcase
                end
            end
            S_READ: begin
                if (!i_res_full) begin
                    n_rp = rd_nx;
                    if ((rd_s == r1md_pkg::DS_ONLINE) || (rd_s == r1md_pkg::DS_SCRUB)) begin
                        o_res_push    = 1'b1;
                        o_res.status  = r1md_pkg::ST_OK;
                        o_res.target  = rd_x;
                        o_res.phys    = r_cmd.phys;
                        n_state       = S_IDLE;
                    end else if ((rd_s > r1md_pkg::DS_HOTSPARE) || (r_try == nc)) begin
                        o_res_push    = 1'b1;
                        o_res.status  = r1md_pkg::ST_RD_OFFLINE;
                        n_state       = S_IDLE;
                    end else begin
                        n_try = r_try + NW'(1);
                    end
                end
            end
            S_WRITE: begin
                if (!i_res_full) begin
                    if (w_bad) begin
                        o_res_push   = 1'b1;
                        o_res.status = r1md_pkg::ST_BAD_VOL;
                        n_state      = S_IDLE;
                    end else if (wq == '0) begin
                        o_res_push   = 1'b1;
                        o_res.status = r1md_pkg::ST_NO_TARGET;
                        n_state      = S_IDLE;
                    end else begin
                        n_wi = r_wi + IW'(1);
                        if (wq[r_wi]) begin
                            o_res_push     = 1'b1;
                            o_res.status   = r1md_pkg::ST_OK;
                            o_res.target   = r_wi;
                            o_res.phys     = r_cmd.phys;
                            o_res.is_write = 1'b1;
                            o_res.last     = ~w_more;
                            if (!w_more) begin
                                n_state = S_IDLE;
                            end
                        end
                    end
                end
            end
            S_ONE: begin
                if (!i_res_full) begin
                    o_res_push   = 1'b1;
                    o_res.status = r1md_pkg::ST_OK;
                    o_res.target = r_cmd.idx;
                    n_state      = S_IDLE;
                    case (r_cmd.cls)
                        r1md_pkg::CLS_SET: begin
                            if (!idx_used) begin
                                o_res.status = r1md_pkg::ST_BAD_DISK;
                            end else if (cur == r_cmd.ns) begin
                                o_res.status = r1md_pkg::ST_OK;
                            end else if (!disk_move_ok(cur, r_cmd.ns)) begin
                                o_res.status = r1md_pkg::ST_BAD_DISK;
                            end else if (!drv[VW]) begin
                                o_res.status = r1md_pkg::ST_BAD_VOL;
                            end else if (!vol_move_ok(r_vol, drv[VW-1:0])) begin
                                o_res.status = r1md_pkg::ST_BAD_VOL;
                            end else begin
                                ds_we = 1'b1;
                                n_vol = drv[VW-1:0];
                            end
                        end
                        r1md_pkg::CLS_LOAD: begin
                            // unchecked: the disk is written even if the mix is invalid
                            if (idx_stored) begin
                                ds_we = 1'b1;
                                if (drv[VW]) begin
                                    n_vol = drv[VW-1:0];
                                end else begin
                                    o_res.status = r1md_pkg::ST_BAD_VOL;
                                end
                            end
                        end
                        default: begin
                            o_res.target = '0;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_res.vol = n_vol;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rp    <= '0;
            r_vol   <= r1md_pkg::VS_ONLINE;
            for (int i = 0; i < NDISK; i++) begin
                r_ds[i] <= r1md_pkg::DS_ONLINE;
            end
        end else begin
            r_state <= n_state;
            r_rp    <= n_rp;
            r_vol   <= n_vol;
            if (ds_we) begin
                r_ds[r_cmd.idx[DI_W-1:0]] <= r_cmd.ns;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_try <= n_try;
        r_wi  <= n_wi;
    end

endmodule

`default_nettype wire

>>> rtl/core/raid1_mirror_dispatch.sv
// An accepted item goes through the command queue to the engine, which handles a
// state op or walks the disks for a read (one try per cycle) or a write (one disk
// per cycle) while the result queue is not full; results reach the ports through
// the result queue. The engine takes no new item until it is done with the last.
// Reset (synchronous, active low): all disks online, volume online, read
// pointer 0, num_chunks 2, meta_offset 0, both queues empty.
// ----------------------------------------------------------------------------
// raid1_mirror_dispatch
// One-to-eight way mirror dispatcher: read balancing, write fan-out and
// checked disk/volume state changes.
// ----------------------------------------------------------------------------
`default_nettype none

module raid1_mirror_dispatch #(
    parameter int MAX_DISKS = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input queue side
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [r1md_pkg::OP_W-1:0]         i_opcode,
    input  wire logic [r1md_pkg::LBA_W-1:0]        i_lba,
    input  wire logic [r1md_pkg::IDX_W-1:0]        i_disk_index,
    input  wire logic [r1md_pkg::DISK_W-1:0]       i_new_disk_state,
    // result queue side
    output logic                                   empty,
    input  wire logic                              pop,
    output logic [r1md_pkg::ST_W-1:0]              o_status,
    output logic [r1md_pkg::IDX_W-1:0]             o_target_disk,
    output logic [r1md_pkg::PHYS_W-1:0]            o_phys_block,
    output logic                                   o_is_write,
    output logic [r1md_pkg::VOL_W-1:0]             o_volume_status,
    output logic                                   o_last,
    // configuration write channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [r1md_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [r1md_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 2;

    logic [r1md_pkg::NC_W-1:0]  r_num_chunks;
    logic [r1md_pkg::OFS_W-1:0] r_meta_offset;

    r1md_pkg::t_cmd front_cmd;
    r1md_pkg::t_cmd q_cmd;
    logic           q_empty;
    logic           back_pop;
    r1md_pkg::t_res back_res;
    logic           back_push;
    logic           res_full;
    r1md_pkg::t_res out_res;

    // Config is taken every cycle, unchecked: the user has it only written while the block is idle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_chunks  <= r1md_pkg::NC_W'(2);
            r_meta_offset <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                r1md_pkg::CFG_NUM_CHUNKS:  r_num_chunks  <= i_cfg_data[r1md_pkg::NC_W-1:0];
                r1md_pkg::CFG_META_OFFSET: r_meta_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front: decode the opcode, add the metadata offset.
    r1md_front u_front (
        .i_opcode         (i_opcode),
        .i_lba            (i_lba),
        .i_disk_index     (i_disk_index),
        .i_new_disk_state (i_new_disk_state),
        .i_meta_offset    (r_meta_offset),
        .o_cmd            (front_cmd)
    );

    // Command queue decouples the front from the engine.
    r1md_fifo #(
        .W     ($bits(r1md_pkg::t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (back_pop),
        .o_data  (q_cmd),
        .o_empty (q_empty)
    );

    // Back: owns disk/volume state and walks disks one per cycle while the result queue is not full.
    r1md_back #(
        .MAX_DISKS (MAX_DISKS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_num_chunks (r_num_chunks),
        .i_cmd        (q_cmd),
        .i_cmd_valid  (~q_empty),
        .o_cmd_pop    (back_pop),
        .o_res        (back_res),
        .o_res_push   (back_push),
        .i_res_full   (res_full)
    );

    // Result queue: the engine keeps going while the consumer stalls, until this queue is full.
    r1md_fifo #(
        .W     ($bits(r1md_pkg::t_res)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (out_res),
        .o_empty (empty)
    );

    assign o_status        = out_res.status;
    assign o_target_disk   = out_res.target;
    assign o_phys_block    = out_res.phys;
    assign o_is_write      = out_res.is_write;
    assign o_volume_status = out_res.vol;
    assign o_last          = out_res.last;

endmodule

`default_nettype wire

>>> rtl/core/r1md_checker.sv
// ----------------------------------------------------------------------------
// r1md_checker
// Port-level checks on the result side of the mirror dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

`include "raid1_mirror_dispatch_macros.svh"

module r1md_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            empty,
    input wire logic                            pop,
    input wire logic [r1md_pkg::ST_W-1:0]       o_status,
    input wire logic [r1md_pkg::IDX_W-1:0]      o_target_disk,
    input wire logic [r1md_pkg::PHYS_W-1:0]     o_phys_block,
    input wire logic                            o_is_write,
    input wire logic [r1md_pkg::VOL_W-1:0]      o_volume_status,
    input wire logic                            o_last
);

    // an issued write always carries ok status
    `R1MD_ASSERT_IMP(a_write_ok, !empty && o_is_write, o_status == r1md_pkg::ST_OK, "write with error status")

    // any error result is the single result of its transaction
    `R1MD_ASSERT_IMP(a_err_last, !empty && (o_status != r1md_pkg::ST_OK), o_last && !o_is_write, "error result not last")

    // a stalled result stays put
    `R1MD_ASSERT_NXT(a_hold, !empty && !pop, !empty && $stable(o_phys_block) && $stable(o_target_disk) && $stable(o_status), "result changed while stalled")

    // results of one write fan-out share volume status and are all writes
    `R1MD_ASSERT_IMP(a_fanout, $past(i_rst_n) && $past(!empty && pop && o_is_write && !o_last) && !empty, o_is_write && (o_volume_status == $past(o_volume_status)), "write fan-out broken")

endmodule

bind raid1_mirror_dispatch r1md_checker u_r1md_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .empty           (empty),
    .pop             (pop),
    .o_status        (o_status),
    .o_target_disk   (o_target_disk),
    .o_phys_block    (o_phys_block),
    .o_is_write      (o_is_write),
    .o_volume_status (o_volume_status),
    .o_last          (o_last)
);

`default_nettype wire

>>> verif/tb_raid1_mirror_dispatch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_raid1_mirror_dispatch
// Self-checking bench for the mirror dispatcher. A queued driver pushes host
// requests, an in-bench model of disk and volume state predicts every issued
// command, and a monitor checks each popped result in order. Runs a directed
// sequence, then random phases under different chunk counts and offsets.
// ----------------------------------------------------------------------------
module tb_raid1_mirror_dispatch;

    localparam int MAX_DISKS       = 8;
    localparam int WDOG_LIMIT      = 2000;   // cycles with no transaction at all
    localparam int DRAIN_CYCLES    = 24;     // settle time after the last result is back
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 36;

    localparam int OP_W       = r1md_pkg::OP_W;
    localparam int LBA_W      = r1md_pkg::LBA_W;
    localparam int IDX_W      = r1md_pkg::IDX_W;
    localparam int DISK_W     = r1md_pkg::DISK_W;
    localparam int ST_W       = r1md_pkg::ST_W;
    localparam int PHYS_W     = r1md_pkg::PHYS_W;
    localparam int VOL_W      = r1md_pkg::VOL_W;
    localparam int NC_W       = r1md_pkg::NC_W;
    localparam int OFS_W      = r1md_pkg::OFS_W;
    localparam int CFG_IDX_W  = r1md_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = r1md_pkg::CFG_DATA_W;

    localparam logic [OP_W-1:0]   OP_SPARE   = 3'd7;   // undefined opcode
    localparam logic [DISK_W-1:0] DS_CORRUPT = 3'd7;   // status outside the legal set
    localparam logic [LBA_W-1:0]  LBA_MAX    = '1;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [LBA_W-1:0]  lba;
        logic [IDX_W-1:0]  idx;
        logic [DISK_W-1:0] ns;
    } t_req;

    // ------------------------------------------------------------------------
    // clock, reset, DUT
    // ------------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  push = 1'b0;
    logic                  full;
    logic [OP_W-1:0]       i_opcode = '0;
    logic [LBA_W-1:0]      i_lba = '0;
    logic [IDX_W-1:0]      i_disk_index = '0;
    logic [DISK_W-1:0]     i_new_disk_state = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [ST_W-1:0]       o_status;
    logic [IDX_W-1:0]      o_target_disk;
    logic [PHYS_W-1:0]     o_phys_block;
    logic                  o_is_write;
    logic [VOL_W-1:0]      o_volume_status;
    logic                  o_last;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    raid1_mirror_dispatch #(
        .MAX_DISKS(MAX_DISKS)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_opcode         (i_opcode),
        .i_lba            (i_lba),
        .i_disk_index     (i_disk_index),
        .i_new_disk_state (i_new_disk_state),
        .empty            (empty),
        .pop              (pop),
        .o_status         (o_status),
        .o_target_disk    (o_target_disk),
        .o_phys_block     (o_phys_block),
        .o_is_write       (o_is_write),
        .o_volume_status  (o_volume_status),
        .o_last           (o_last),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    t_req           pending_reqs [$];     // requests not yet accepted by the DUT
    r1md_pkg::t_res expected_cmds [$];    // predicted results, oldest first

    int send_gap     = 0;
    int pop_gap      = 0;
    int idle_cycles  = 0;
    int err_count    = 0;
    int items_queued = 0;
    bit tx_idle_en   = 1'b1;
    bit rx_idle_en   = 1'b1;

    // mirror state as the bench sees it
    logic [MAX_DISKS-1:0][DISK_W-1:0] disk_st;
    logic [VOL_W-1:0]                 vol_st;
    logic [IDX_W-1:0]                 rr_next;
    logic [NC_W-1:0]                  chunks_cfg;
    logic [OFS_W-1:0]                 meta_ofs_cfg;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // 0 acts as 1, anything past the disk count is clamped
    function automatic int used_disks();
        int n;
        n = int'(chunks_cfg);
        if (n < 1) n = 1;
        if (n > MAX_DISKS) n = MAX_DISKS;
        return n;
    endfunction

    // volume status implied by the used disks; 0 when the mix is not legal
    function automatic bit derive_volume(input logic [MAX_DISKS-1:0][DISK_W-1:0] ds,
                                         output logic [VOL_W-1:0] vol);
        int n, n_on, n_off, n_scrub, n_reb;
        n = used_disks();
        n_on = 0;
        n_off = 0;
        n_scrub = 0;
        n_reb = 0;
        vol = r1md_pkg::VS_ONLINE;
        for (int i = 0; i < n; i++) begin
            if (ds[i] > r1md_pkg::DS_HOTSPARE) return 1'b0;
            case (ds[i])
                r1md_pkg::DS_ONLINE:  n_on++;
                r1md_pkg::DS_OFFLINE: n_off++;
                r1md_pkg::DS_SCRUB:   n_scrub++;
                r1md_pkg::DS_REBUILD: n_reb++;
                default: ;
            endcase
        end
        if (n_on == n) vol = r1md_pkg::VS_ONLINE;
        else if (n_on == 0) vol = r1md_pkg::VS_OFFLINE;
        else if (n_scrub != 0) vol = r1md_pkg::VS_SCRUB;
        else if (n_reb != 0) vol = r1md_pkg::VS_REBUILD;
        else if (n_off != 0) vol = r1md_pkg::VS_DEGRADED;
        else return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit disk_move_legal(input logic [DISK_W-1:0] from_st,
                                           input logic [DISK_W-1:0] to_st);
        case (from_st)
            r1md_pkg::DS_ONLINE:
                return to_st == r1md_pkg::DS_OFFLINE || to_st == r1md_pkg::DS_SCRUB;
            r1md_pkg::DS_OFFLINE:
                return to_st == r1md_pkg::DS_REBUILD;
            r1md_pkg::DS_SCRUB, r1md_pkg::DS_REBUILD:
                return to_st == r1md_pkg::DS_ONLINE;
            r1md_pkg::DS_HOTSPARE:
                return to_st == r1md_pkg::DS_REBUILD;
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic bit vol_move_legal(input logic [VOL_W-1:0] from_st,
                                          input logic [VOL_W-1:0] to_st);
        case (from_st)
            r1md_pkg::VS_ONLINE:
                return to_st == r1md_pkg::VS_OFFLINE || to_st == r1md_pkg::VS_DEGRADED;
            r1md_pkg::VS_SCRUB:
                return to_st == r1md_pkg::VS_ONLINE || to_st == r1md_pkg::VS_OFFLINE ||
                       to_st == r1md_pkg::VS_DEGRADED || to_st == r1md_pkg::VS_SCRUB;
            r1md_pkg::VS_BUILDING:
                return to_st == r1md_pkg::VS_ONLINE || to_st == r1md_pkg::VS_OFFLINE ||
                       to_st == r1md_pkg::VS_BUILDING;
            r1md_pkg::VS_REBUILD:
                return to_st == r1md_pkg::VS_ONLINE || to_st == r1md_pkg::VS_OFFLINE ||
                       to_st == r1md_pkg::VS_REBUILD;
            r1md_pkg::VS_DEGRADED:
                return to_st == r1md_pkg::VS_OFFLINE || to_st == r1md_pkg::VS_REBUILD ||
                       to_st == r1md_pkg::VS_DEGRADED;
            default:
                return 1'b0;   // offline is terminal
        endcase
    endfunction

    // checked disk state change; all-or-nothing
    function automatic logic [ST_W-1:0] checked_change(input logic [IDX_W-1:0] idx,
                                                       input logic [DISK_W-1:0] ns);
        logic [MAX_DISKS-1:0][DISK_W-1:0] trial;
        logic [VOL_W-1:0]                 vol;
        if (int'(idx) >= used_disks()) return r1md_pkg::ST_BAD_DISK;
        if (disk_st[idx] == ns) return r1md_pkg::ST_OK;
        if (!disk_move_legal(disk_st[idx], ns)) return r1md_pkg::ST_BAD_DISK;
        trial = disk_st;
        trial[idx] = ns;
        if (!derive_volume(trial, vol)) return r1md_pkg::ST_BAD_VOL;
        if (!vol_move_legal(vol_st, vol)) return r1md_pkg::ST_BAD_VOL;
        disk_st = trial;
        vol_st = vol;
        return r1md_pkg::ST_OK;
    endfunction

    function automatic bit takes_write(input logic [DISK_W-1:0] s);
        return s == r1md_pkg::DS_ONLINE || s == r1md_pkg::DS_SCRUB ||
               s == r1md_pkg::DS_REBUILD;
    endfunction

    // volume status is sampled at the time the result is formed
    function automatic void queue_expected(input logic [ST_W-1:0] st,
                                           input logic [IDX_W-1:0] tgt,
                                           input logic [PHYS_W-1:0] blk,
                                           input logic wr, input logic last);
        r1md_pkg::t_res rec;
        rec.status   = st;
        rec.target   = tgt;
        rec.phys     = blk;
        rec.is_write = wr;
        rec.vol      = vol_st;
        rec.last     = last;
        expected_cmds.push_back(rec);
    endfunction

    function automatic void dispatch_predict(input t_req rq);
        logic [PHYS_W-1:0] blk;
        logic [VOL_W-1:0]  vol;
        logic [ST_W-1:0]   st;
        logic [DISK_W-1:0] s;
        int                n, x, usable, k;
        blk = PHYS_W'(rq.lba) + PHYS_W'(meta_ofs_cfg);
        n = used_disks();
        case (rq.op)
            r1md_pkg::OP_READ: begin
                // round-robin, skipping disks that cannot serve a read
                for (int t = 0; t <= n; t++) begin
                    x = int'(rr_next);
                    if (x >= n) x = 0;
                    rr_next = (x + 1 >= n) ? '0 : IDX_W'(x + 1);
                    s = disk_st[x];
                    if (s == r1md_pkg::DS_ONLINE || s == r1md_pkg::DS_SCRUB) begin
                        queue_expected(r1md_pkg::ST_OK, IDX_W'(x), blk, 1'b0, 1'b1);
                        return;
                    end
                    if (s > r1md_pkg::DS_HOTSPARE) break;
                end
                queue_expected(r1md_pkg::ST_RD_OFFLINE, '0, '0, 1'b0, 1'b1);
            end
            r1md_pkg::OP_WRITE: begin
                for (int i = 0; i < n; i++) begin
                    if (disk_st[i] > r1md_pkg::DS_HOTSPARE) begin
                        queue_expected(r1md_pkg::ST_BAD_VOL, '0, '0, 1'b0, 1'b1);
                        return;
                    end
                end
                usable = 0;
                for (int i = 0; i < n; i++) begin
                    if (takes_write(disk_st[i])) usable++;
                end
                if (usable == 0) begin
                    queue_expected(r1md_pkg::ST_NO_TARGET, '0, '0, 1'b0, 1'b1);
                    return;
                end
                k = 0;
                for (int i = 0; i < n; i++) begin
                    if (takes_write(disk_st[i])) begin
                        k++;
                        queue_expected(r1md_pkg::ST_OK, IDX_W'(i), blk, 1'b1, k == usable);
                    end
                end
            end
            r1md_pkg::OP_SET, r1md_pkg::OP_IOERR: begin
                st = checked_change(rq.idx, (rq.op == r1md_pkg::OP_IOERR) ?
                                            r1md_pkg::DS_OFFLINE : rq.ns);
                queue_expected(st, rq.idx, '0, 1'b0, 1'b1);
            end
            r1md_pkg::OP_LOAD: begin
                // disk is written even when the resulting mix is illegal
                disk_st[rq.idx] = rq.ns;
                st = r1md_pkg::ST_OK;
                if (derive_volume(disk_st, vol)) vol_st = vol;
                else st = r1md_pkg::ST_BAD_VOL;
                queue_expected(st, rq.idx, '0, 1'b0, 1'b1);
            end
            default: begin
                queue_expected(r1md_pkg::ST_OK, '0, '0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [LBA_W-1:0] rand_lba();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return LBA_MAX;
            default: return LBA_W'({$urandom(), $urandom()});
        endcase
    endfunction

    function automatic logic [DISK_W-1:0] rand_ns();
        return DISK_W'($urandom_range(0, 7));
    endfunction

    function automatic void add_req(input logic [OP_W-1:0] op, input logic [LBA_W-1:0] lba,
                                    input logic [IDX_W-1:0] idx,
                                    input logic [DISK_W-1:0] ns);
        t_req rq;
        rq.op  = op;
        rq.lba = lba;
        rq.idx = idx;
        rq.ns  = ns;
        pending_reqs.push_back(rq);
        items_queued++;
    endfunction

    // host read or write; unused fields carry random junk
    function automatic void add_rw();
        add_req($urandom_range(0, 1) ? r1md_pkg::OP_WRITE : r1md_pkg::OP_READ, rand_lba(),
                IDX_W'($urandom_range(0, 7)), rand_ns());
    endfunction

    // unchecked loads bring every disk, and so the volume, back online
    function automatic void restore_all_online();
        for (int i = 0; i < MAX_DISKS; i++) begin
            add_req(r1md_pkg::OP_LOAD, rand_lba(), IDX_W'(i), r1md_pkg::DS_ONLINE);
        end
    endfunction

    // mostly legal maintenance flows with random I/O mixed in, plus noise
    function automatic void gen_sequence();
        int n, d, d2;
        n  = used_disks();
        d  = $urandom_range(0, n - 1);
        d2 = $urandom_range(0, n - 1);
        case ($urandom_range(0, 11))
            0, 1, 2, 3: begin
                repeat ($urandom_range(1, 4)) add_rw();
            end
            4, 5: begin
                // disk fails, gets rebuilt, comes back
                add_req(r1md_pkg::OP_IOERR, rand_lba(), IDX_W'(d), rand_ns());
                add_rw();
                add_req(r1md_pkg::OP_SET, rand_lba(), IDX_W'(d), r1md_pkg::DS_REBUILD);
                add_rw();
                add_req(r1md_pkg::OP_SET, rand_lba(), IDX_W'(d), r1md_pkg::DS_ONLINE);
            end
            6: begin
                add_req(r1md_pkg::OP_SET, rand_lba(), IDX_W'(d), r1md_pkg::DS_SCRUB);
                add_rw();
                add_req(r1md_pkg::OP_SET, rand_lba(), IDX_W'(d), r1md_pkg::DS_ONLINE);
            end
            7: begin
                // failed disk replaced by a hot spare
                add_req(r1md_pkg::OP_IOERR, rand_lba(), IDX_W'(d), rand_ns());
                add_req(r1md_pkg::OP_LOAD, rand_lba(), IDX_W'(d), r1md_pkg::DS_HOTSPARE);
                add_req(r1md_pkg::OP_SET, rand_lba(), IDX_W'(d), r1md_pkg::DS_REBUILD);
                add_rw();
                add_req(r1md_pkg::OP_SET, rand_lba(), IDX_W'(d), r1md_pkg::DS_ONLINE);
            end
            8: begin
                // double failure; may take the volume offline
                add_req(r1md_pkg::OP_IOERR, rand_lba(), IDX_W'(d), rand_ns());
                add_req(r1md_pkg::OP_IOERR, rand_lba(), IDX_W'(d2), rand_ns());
                add_rw();
                add_rw();
                add_req(r1md_pkg::OP_SET, rand_lba(), IDX_W'(d), r1md_pkg::DS_REBUILD);
                add_req(r1md_pkg::OP_SET, rand_lba(), IDX_W'(d), r1md_pkg::DS_ONLINE);
                add_req(r1md_pkg::OP_SET, rand_lba(), IDX_W'(d2), r1md_pkg::DS_REBUILD);
                add_req(r1md_pkg::OP_SET, rand_lba(), IDX_W'(d2), r1md_pkg::DS_ONLINE);
            end
            9, 10: begin
                repeat ($urandom_range(1, 3)) begin
                    add_req(OP_W'($urandom_range(0, 7)), rand_lba(),
                            IDX_W'($urandom_range(0, 7)), rand_ns());
                end
            end
            default: restore_all_online();
        endcase
    endfunction

    // config transaction; held until the DUT takes it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [NC_W-1:0] chunks, input logic [OFS_W-1:0] ofs);
        // upper data bits are junk the DUT must drop
        write_reg(r1md_pkg::CFG_NUM_CHUNKS, {(CFG_DATA_W - NC_W)'($urandom()), chunks});
        chunks_cfg = chunks;
        write_reg(r1md_pkg::CFG_META_OFFSET, ofs);
        meta_ofs_cfg = ofs;
    endtask

    // sender holds off until every predicted result is back, then lets the
    // engine settle before the next config write
    task automatic drain_and_settle();
        while (pending_reqs.size() != 0 || expected_cmds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        err_count++;
    endtask

    // ------------------------------------------------------------------------
    // driver: request side, changes on the falling edge
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (send_gap > 0) begin
            send_gap = send_gap - 1;
            push <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
            push <= 1'b1;
            {i_opcode, i_lba, i_disk_index, i_new_disk_state} <= pending_reqs[0];
        end else begin
            push <= 1'b0;
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (pop_gap > 0) begin
            pop_gap = pop_gap - 1;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: predicts on request transactions, checks result transactions,
    // and runs the watchdog. Request side first so a same-edge result sees
    // its prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_req           rq;
        r1md_pkg::t_res got, want;
        bit             moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (push && !full) begin
                rq = {i_opcode, i_lba, i_disk_index, i_new_disk_state};
                dispatch_predict(rq);
                void'(pending_reqs.pop_front());
                if (tx_idle_en) send_gap = pick_gap();
                moved = 1'b1;
            end
            if (pop && !empty) begin
                got = {o_status, o_target_disk, o_phys_block, o_is_write,
                       o_volume_status, o_last};
                if (expected_cmds.size() == 0) begin
                    note_mismatch("result with nothing outstanding", 64'(got), '0);
                end else begin
                    want = expected_cmds.pop_front();
                    if (got.status != want.status)
                        note_mismatch("status", 64'(got.status), 64'(want.status));
                    if (got.target != want.target)
                        note_mismatch("target_disk", 64'(got.target), 64'(want.target));
                    if (got.phys != want.phys)
                        note_mismatch("phys_block", 64'(got.phys), 64'(want.phys));
                    if (got.is_write != want.is_write)
                        note_mismatch("is_write", 64'(got.is_write), 64'(want.is_write));
                    if (got.vol != want.vol)
                        note_mismatch("volume_status", 64'(got.vol), 64'(want.vol));
                    if (got.last != want.last)
                        note_mismatch("last", 64'(got.last), 64'(want.last));
                end
                if (rx_idle_en) pop_gap = pick_gap();
                moved = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) moved = 1'b1;
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WDOG_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    logic [NC_W-1:0] chunk_plan [PHASES] = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd4, 4'd6, 4'd2, 4'd8};

    initial begin
        logic [NC_W-1:0]  nc;
        logic [OFS_W-1:0] ofs;
        int               start;
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        disk_st      = '0;
        vol_st       = r1md_pkg::VS_ONLINE;
        rr_next      = '0;
        chunks_cfg   = 4'd2;
        meta_ofs_cfg = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: three-way mirror, offset that carries into the top bit
        set_config(4'd3, '1);
        add_req(r1md_pkg::OP_READ, '0, 3'd0, r1md_pkg::DS_ONLINE);
        add_req(r1md_pkg::OP_READ, LBA_MAX, 3'd7, DS_CORRUPT);
        add_req(r1md_pkg::OP_WRITE, LBA_MAX, 3'd0, r1md_pkg::DS_ONLINE);  // fans out to all three
        add_req(r1md_pkg::OP_SET, '0, 3'd1, r1md_pkg::DS_ONLINE);         // same state, no-op
        add_req(r1md_pkg::OP_SET, '0, 3'd5, r1md_pkg::DS_OFFLINE);        // index past chunk count
        add_req(r1md_pkg::OP_IOERR, '0, 3'd0, DS_CORRUPT);                // volume degraded
        add_req(r1md_pkg::OP_SET, '0, 3'd0, r1md_pkg::DS_SCRUB);          // offline -> scrub refused
        add_req(r1md_pkg::OP_READ, 48'h1234_5678_9abc, 3'd0, r1md_pkg::DS_ONLINE);
        add_req(r1md_pkg::OP_SET, '0, 3'd0, r1md_pkg::DS_REBUILD);
        add_req(r1md_pkg::OP_WRITE, 48'h0000_0000_0001, 3'd0, r1md_pkg::DS_ONLINE);
        add_req(r1md_pkg::OP_SET, '0, 3'd0, r1md_pkg::DS_ONLINE);
        add_req(r1md_pkg::OP_SET, '0, 3'd2, r1md_pkg::DS_SCRUB);
        add_req(r1md_pkg::OP_READ, LBA_MAX, 3'd0, r1md_pkg::DS_ONLINE);
        add_req(r1md_pkg::OP_SET, '0, 3'd2, r1md_pkg::DS_ONLINE);
        // illegal mix, disk still written
        add_req(r1md_pkg::OP_LOAD, '0, 3'd1, r1md_pkg::DS_HOTSPARE);
        // online -> rebuild volume refused
        add_req(r1md_pkg::OP_SET, '0, 3'd1, r1md_pkg::DS_REBUILD);
        add_req(r1md_pkg::OP_LOAD, '0, 3'd1, DS_CORRUPT);
        add_req(r1md_pkg::OP_READ, '0, 3'd0, r1md_pkg::DS_ONLINE);   // may stop on the corrupt disk
        add_req(r1md_pkg::OP_WRITE, '0, 3'd0, r1md_pkg::DS_ONLINE);  // corrupt disk blocks the write
        add_req(r1md_pkg::OP_LOAD, '0, 3'd1, r1md_pkg::DS_ONLINE);
        add_req(r1md_pkg::OP_IOERR, '0, 3'd0, r1md_pkg::DS_ONLINE);
        add_req(r1md_pkg::OP_IOERR, '0, 3'd1, r1md_pkg::DS_ONLINE);
        add_req(r1md_pkg::OP_IOERR, '0, 3'd2, r1md_pkg::DS_ONLINE);  // volume offline
        add_req(r1md_pkg::OP_READ, LBA_MAX, 3'd0, r1md_pkg::DS_ONLINE);   // nothing to read from
        add_req(r1md_pkg::OP_WRITE, LBA_MAX, 3'd0, r1md_pkg::DS_ONLINE);  // nothing to write to
        add_req(OP_SPARE, LBA_MAX, 3'd7, DS_CORRUPT);                // undefined opcode
        drain_and_settle();

        // random phases; each ends with a full drain before reconfiguring
        for (int p = 0; p < PHASES; p++) begin
            tx_idle_en = (p % 3 != 1);
            rx_idle_en = (p % 3 != 2);
            nc = (p == 5) ? NC_W'($urandom_range(0, 15)) : chunk_plan[p];
            ofs = (p % 3 == 0) ? '0 : (p % 3 == 1) ? '1 : OFS_W'($urandom());
            set_config(nc, ofs);
            restore_all_online();
            start = items_queued;
            while (items_queued - start < ITEMS_PER_PHASE) gen_sequence();
            drain_and_settle();
        end

        if (err_count == 0 && expected_cmds.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
